// ----- hw/rtl/egw_pkg.sv -----
// ----------------------------------------------------------------------------
// egw_pkg
// Shared types and constants of the Exp-Golomb NAL payload writer: operation
// codes, queue entry kinds and the entry passed from front to back.
// ----------------------------------------------------------------------------
package egw_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // operation codes on the request side
   localparam logic [2:0] OP_START = 3'd0;
   localparam logic [2:0] OP_UE    = 3'd1;
   localparam logic [2:0] OP_SE    = 3'd2;
   localparam logic [2:0] OP_FLOAT = 3'd3;
   localparam logic [2:0] OP_FLUSH = 3'd4;

   // queue entry kinds
   localparam logic [1:0] KIND_START  = 2'd0;
   localparam logic [1:0] KIND_CODE   = 2'd1;
   localparam logic [1:0] KIND_FLUSH  = 2'd2;
   localparam logic [1:0] KIND_REJECT = 2'd3;

   localparam logic [7:0] HDR_TYPE_RESET = 8'd24;
   localparam logic [7:0] ESC_BYTE       = 8'h03;
   localparam logic [7:0] ESC_LIMIT      = 8'd4;
   localparam logic [7:0] RECENT_RESET   = 8'hFF;

   // one code segment: nbits significant bits of word, left aligned, sent
   // after nbits-1 leading zeros; tail counts the bits of later segments of
   // the same item
   typedef struct packed {
      logic [1:0]  kind;
      logic [32:0] word;
      logic [5:0]  nbits;
      logic [4:0]  tail;
   } egw_entry_type;

endpackage

// ----- hw/rtl/egw_queue.sv -----
// ----------------------------------------------------------------------------
// egw_queue
// Small register FIFO of code segments between the front and the back part.
// ----------------------------------------------------------------------------
module egw_queue
   import egw_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  egw_entry_type push_entry,
   input  logic          pop,
   output egw_entry_type pop_entry,
   output logic          full,
   output logic          empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   egw_entry_type      slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign pop_entry = slot_ff[rd_ptr_ff];

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(DEPTH - 1)) begin
         return '0;
      end
      return p + PTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = next_ptr(wr_ptr_ff);
      end
      if (pop) begin
         rd_ptr_in = next_ptr(rd_ptr_ff);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- hw/rtl/egw_front.sv -----
// ----------------------------------------------------------------------------
// egw_front
// Accepts request words, checks ranges and turns each one into queue
// entries. A shared normaliser finds the code length a byte or a fine step
// per cycle; nonzero float words run it three times (mantissa, exponent, mantissa code).
// ----------------------------------------------------------------------------
module egw_front
   import egw_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [2:0]    req_operation,
   input  logic [30:0]   req_unsigned_value,
   input  logic [31:0]   req_signed_value,
   input  logic [31:0]   req_float_bits,
   input  logic          q_full,
   output logic          q_push,
   output egw_entry_type q_entry
);

   localparam logic [2:0] F_IDLE = 3'd0;
   localparam logic [2:0] F_MANT = 3'd1;
   localparam logic [2:0] F_ESEG = 3'd2;
   localparam logic [2:0] F_SEG1 = 3'd3;
   localparam logic [2:0] F_PUSH = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [32:0]   nw_ff, nw_in;
   logic [5:0]    ns_ff, ns_in;
   egw_entry_type ent_ff, ent_in;
   egw_entry_type seg2_ff, seg2_in;
   logic          two_ff, two_in;
   logic [4:0]    tail_ff, tail_in;
   logic          sign_ff, sign_in;
   logic [7:0]    exp_ff, exp_in;
   logic [31:0]   c1_ff, c1_in;

   // normaliser step
   logic [7:0]    top8;
   logic [2:0]    lz8;
   logic [3:0]    sh8;
   logic [32:0]   step_word;
   logic [5:0]    step_ns;

   always_comb begin
      top8 = nw_ff[32:25];
      lz8  = 3'd7;
      for (int i = 0; i < 8; i++) begin
         if (top8[i]) begin
            lz8 = 3'(7 - i);
         end
      end
      sh8       = (top8 == 8'h00) ? 4'd8 : {1'b0, lz8};
      step_word = nw_ff << sh8;
      step_ns   = ns_ff + {2'b00, sh8};
   end

   assign req_tready = (state_ff == F_IDLE);
   assign q_push     = (state_ff == F_PUSH) && !q_full;
   assign q_entry    = ent_ff;

   logic [32:0]        se_dbl;
   logic [32:0]        se_code;
   logic [7:0]         f_exp;
   logic [22:0]        f_frac;
   logic [23:0]        mant;
   logic [31:0]        fixed;
   logic [31:0]        flip;
   logic signed [8:0]  ev;
   logic signed [9:0]  ev2;
   logic [9:0]         ecode;
   logic [5:0]         nbits;
   logic [6:0]         tail_w;

   always_comb begin
      state_in = state_ff;
      nw_in    = nw_ff;
      ns_in    = ns_ff;
      ent_in   = ent_ff;
      seg2_in  = seg2_ff;
      two_in   = two_ff;
      tail_in  = tail_ff;
      sign_in  = sign_ff;
      exp_in   = exp_ff;
      c1_in    = c1_ff;

      se_dbl  = {req_signed_value, 1'b0};
      se_code = ($signed(req_signed_value) > 32'sd0) ? se_dbl - 33'd1 : 33'd0 - se_dbl;
      f_exp   = req_float_bits[30:23];
      f_frac  = req_float_bits[22:0];

      mant  = nw_ff[32:9];
      fixed = sign_ff ? 32'd0 - {1'b0, mant, 7'd0} : {1'b0, mant, 7'd0};
      for (int i = 0; i < 32; i++) begin
         flip[i] = fixed[31 - i];
      end
      if (exp_ff != 8'h00) begin
         ev = $signed({1'b0, exp_ff}) - 9'sd126;
      end else begin
         ev = -9'sd125 - $signed({3'b000, ns_ff});
      end
      ev2   = {ev, 1'b0};
      ecode = (ev > 9'sd0) ? 10'(ev2 - 10'sd1) : 10'(-ev2);

      nbits  = 6'd33 - ns_ff;
      tail_w = {nbits, 1'b0} - 7'd1;

      case (state_ff)
         F_IDLE: begin
            if (req_tvalid) begin
               two_in  = 1'b0;
               tail_in = '0;
               ns_in   = '0;
               ent_in  = '{kind: KIND_REJECT, word: '0, nbits: '0, tail: '0};
               state_in = F_PUSH;
               case (req_operation)
                  OP_START: ent_in.kind = KIND_START;
                  OP_FLUSH: ent_in.kind = KIND_FLUSH;
                  OP_UE: begin
                     if (req_unsigned_value != 31'h7FFF_FFFF) begin
                        nw_in    = {2'b00, req_unsigned_value} + 33'd1;
                        state_in = F_SEG1;
                     end
                  end
                  OP_SE: begin
                     if (!($signed(req_signed_value) < -32'sd1073741823 ||
                           $signed(req_signed_value) > 32'sd1073741824)) begin
                        nw_in    = se_code + 33'd1;
                        state_in = F_SEG1;
                     end
                  end
                  OP_FLOAT: begin
                     if (f_exp != 8'hFF) begin
                        sign_in = req_float_bits[31];
                        exp_in  = f_exp;
                        if (f_exp == 8'h00 && f_frac == '0) begin
                           // signed zero: a single ue(0)
                           nw_in    = 33'd1;
                           state_in = F_SEG1;
                        end else begin
                           nw_in    = {(f_exp != 8'h00), f_frac, 9'd0};
                           state_in = F_MANT;
                        end
                     end
                  end
                  default: ent_in.kind = KIND_REJECT;
               endcase
            end
         end
         F_MANT: begin
            if (nw_ff[32]) begin
               c1_in    = flip;
               nw_in    = {23'd0, ecode} + 33'd1;
               ns_in    = '0;
               state_in = F_ESEG;
            end else begin
               nw_in = step_word;
               ns_in = step_ns;
            end
         end
         F_ESEG: begin
            if (nw_ff[32]) begin
               seg2_in  = '{kind: KIND_CODE, word: nw_ff, nbits: nbits, tail: '0};
               tail_in  = tail_w[4:0];
               two_in   = 1'b1;
               nw_in    = {1'b0, c1_ff} + 33'd1;
               ns_in    = '0;
               state_in = F_SEG1;
            end else begin
               nw_in = step_word;
               ns_in = step_ns;
            end
         end
         F_SEG1: begin
            if (nw_ff[32]) begin
               ent_in   = '{kind: KIND_CODE, word: nw_ff, nbits: nbits, tail: tail_ff};
               state_in = F_PUSH;
            end else begin
               nw_in = step_word;
               ns_in = step_ns;
            end
         end
         F_PUSH: begin
            if (!q_full) begin
               if (two_ff) begin
                  ent_in = seg2_ff;
                  two_in = 1'b0;
               end else begin
                  state_in = F_IDLE;
               end
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         two_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         two_ff   <= two_in;
      end
   end

   always_ff @(posedge clock) begin
      nw_ff   <= nw_in;
      ns_ff   <= ns_in;
      ent_ff  <= ent_in;
      seg2_ff <= seg2_in;
      tail_ff <= tail_in;
      sign_ff <= sign_in;
      exp_ff  <= exp_in;
      c1_ff   <= c1_in;
   end

endmodule

// ----- hw/rtl/egw_back.sv -----
// ----------------------------------------------------------------------------
// egw_back
// Drains queue entries into the byte packer, up to eight bits a cycle while
// the response word is not stalled, applies emulation prevention to each
// completed byte and drives the registered response word.
// ----------------------------------------------------------------------------
module egw_back
   import egw_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic [7:0]    hdr_type,
   input  logic          q_empty,
   input  egw_entry_type q_entry,
   output logic          q_pop,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [7:0]    rsp_tdata,
   output logic [1:0]    rsp_tuser,
   output logic          rsp_tlast
);

   localparam logic [2:0] B_IDLE  = 3'd0;
   localparam logic [2:0] B_ZERO  = 3'd1;
   localparam logic [2:0] B_BITS  = 3'd2;
   localparam logic [2:0] B_HOLD  = 3'd3;
   localparam logic [2:0] B_START = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [2:0]  resume_ff, resume_in;
   logic [7:0]  pbits_ff, pbits_in;
   logic [2:0]  pcnt_ff, pcnt_in;
   logic [7:0]  rec_mid_ff, rec_mid_in;
   logic [7:0]  rec_new_ff, rec_new_in;
   logic [5:0]  zrem_ff, zrem_in;
   logic [5:0]  brem_ff, brem_in;
   logic [32:0] bw_ff, bw_in;
   logic [4:0]  tail_ff, tail_in;
   logic [7:0]  hold_byte_ff, hold_byte_in;
   logic        hold_last_ff, hold_last_in;
   logic [1:0]  scnt_ff, scnt_in;

   logic        valid_ff, valid_in;
   logic [7:0]  obyte_ff, obyte_in;
   logic        oesc_ff, oesc_in;
   logic        orej_ff, orej_in;
   logic        olast_ff, olast_in;

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = obyte_ff;
   assign rsp_tuser  = {orej_ff, oesc_ff};
   assign rsp_tlast  = olast_ff;

   logic        out_free;
   logic [3:0]  free;
   logic [5:0]  rem;
   logic [3:0]  k;
   logic [7:0]  data8;
   logic [15:0] sh;
   logic [3:0]  newcnt;
   logic [6:0]  item_rem;
   logic [2:0]  next_phase;
   logic        emit;
   logic [7:0]  e_byte;
   logic        e_esc;
   logic        e_rej;
   logic        e_last;
   logic        cpl;
   logic [7:0]  cbyte;
   logic        clast;
   logic [2:0]  cres;
   logic        esc;

   always_comb begin
      state_in     = state_ff;
      resume_in    = resume_ff;
      pbits_in     = pbits_ff;
      pcnt_in      = pcnt_ff;
      rec_mid_in   = rec_mid_ff;
      rec_new_in   = rec_new_ff;
      zrem_in      = zrem_ff;
      brem_in      = brem_ff;
      bw_in        = bw_ff;
      tail_in      = tail_ff;
      hold_byte_in = hold_byte_ff;
      hold_last_in = hold_last_ff;
      scnt_in      = scnt_ff;
      q_pop        = 1'b0;
      emit         = 1'b0;
      e_byte       = 8'h00;
      e_esc        = 1'b0;
      e_rej        = 1'b0;
      e_last       = 1'b0;
      cpl          = 1'b0;
      cbyte        = 8'h00;
      clast        = 1'b0;
      cres         = B_IDLE;
      esc          = 1'b0;

      out_free = !valid_ff || rsp_tready;

      // take as many bits as the current phase has and the byte can hold
      free   = 4'd8 - {1'b0, pcnt_ff};
      rem    = (state_ff == B_ZERO) ? zrem_ff : brem_ff;
      k      = ({2'b00, free} < rem) ? free : rem[3:0];
      data8  = (state_ff == B_BITS) ? bw_ff[32:25] : 8'h00;
      sh     = {pbits_ff, data8} << k;
      newcnt = {1'b0, pcnt_ff} + k;
      if (state_ff == B_ZERO) begin
         item_rem = {1'b0, zrem_ff} - {3'b000, k} + {1'b0, brem_ff} + {2'b00, tail_ff};
         next_phase = (zrem_ff == {2'b00, k}) ? B_BITS : B_ZERO;
      end else begin
         item_rem = {1'b0, brem_ff} - {3'b000, k} + {2'b00, tail_ff};
         next_phase = (brem_ff == {2'b00, k}) ? B_IDLE : B_BITS;
      end

      if (out_free) begin
         case (state_ff)
            B_IDLE: begin
               if (!q_empty) begin
                  q_pop = 1'b1;
                  case (q_entry.kind)
                     KIND_START: begin
                        pbits_in   = 8'h00;
                        pcnt_in    = 3'd0;
                        rec_new_in = RECENT_RESET;
                        scnt_in    = 2'd0;
                        state_in   = B_START;
                     end
                     KIND_CODE: begin
                        zrem_in  = q_entry.nbits - 6'd1;
                        brem_in  = q_entry.nbits;
                        bw_in    = q_entry.word;
                        tail_in  = q_entry.tail;
                        state_in = (q_entry.nbits == 6'd1) ? B_BITS : B_ZERO;
                     end
                     KIND_FLUSH: begin
                        if (pcnt_ff != 3'd0) begin
                           cpl   = 1'b1;
                           cbyte = pbits_ff << (4'd8 - {1'b0, pcnt_ff});
                           clast = 1'b1;
                           cres  = B_IDLE;
                        end
                     end
                     default: begin
                        emit   = 1'b1;
                        e_rej  = 1'b1;
                        e_last = 1'b1;
                     end
                  endcase
               end
            end
            B_ZERO, B_BITS: begin
               if (state_ff == B_ZERO) begin
                  zrem_in = zrem_ff - {2'b00, k};
               end else begin
                  brem_in = brem_ff - {2'b00, k};
                  bw_in   = bw_ff << k;
               end
               if (newcnt == 4'd8) begin
                  cpl   = 1'b1;
                  cbyte = sh[15:8];
                  clast = (item_rem < 7'd8);
                  cres  = next_phase;
               end else begin
                  pbits_in = sh[15:8];
                  pcnt_in  = newcnt[2:0];
                  state_in = next_phase;
               end
            end
            B_HOLD: begin
               emit     = 1'b1;
               e_byte   = hold_byte_ff;
               e_last   = hold_last_ff;
               state_in = resume_ff;
            end
            B_START: begin
               emit = 1'b1;
               case (scnt_ff)
                  2'd2:    e_byte = 8'h01;
                  2'd3:    e_byte = hdr_type;
                  default: e_byte = 8'h00;
               endcase
               scnt_in = scnt_ff + 2'd1;
               if (scnt_ff == 2'd3) begin
                  e_last   = 1'b1;
                  state_in = B_IDLE;
               end
            end
            default: state_in = B_IDLE;
         endcase

         // completed byte: insert the escape after two zero bytes when it is below 0x04
         if (cpl) begin
            esc      = (rec_mid_ff == 8'h00) && (rec_new_ff == 8'h00) && (cbyte < ESC_LIMIT);
            pbits_in = 8'h00;
            pcnt_in  = 3'd0;
            emit     = 1'b1;
            rec_new_in = cbyte;
            if (esc) begin
               e_byte       = ESC_BYTE;
               e_esc        = 1'b1;
               rec_mid_in   = RECENT_RESET;
               hold_byte_in = cbyte;
               hold_last_in = clast;
               resume_in    = cres;
               state_in     = B_HOLD;
            end else begin
               e_byte     = cbyte;
               e_last     = clast;
               rec_mid_in = rec_new_ff;
               state_in   = cres;
            end
         end
      end

      valid_in = valid_ff;
      obyte_in = obyte_ff;
      oesc_in  = oesc_ff;
      orej_in  = orej_ff;
      olast_in = olast_ff;
      if (emit) begin
         valid_in = 1'b1;
         obyte_in = e_byte;
         oesc_in  = e_esc;
         orej_in  = e_rej;
         olast_in = e_last;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= B_IDLE;
         pbits_ff   <= 8'h00;
         pcnt_ff    <= 3'd0;
         rec_mid_ff <= RECENT_RESET;
         rec_new_ff <= RECENT_RESET;
         valid_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pbits_ff   <= pbits_in;
         pcnt_ff    <= pcnt_in;
         rec_mid_ff <= rec_mid_in;
         rec_new_ff <= rec_new_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      resume_ff    <= resume_in;
      zrem_ff      <= zrem_in;
      brem_ff      <= brem_in;
      bw_ff        <= bw_in;
      tail_ff      <= tail_in;
      hold_byte_ff <= hold_byte_in;
      hold_last_ff <= hold_last_in;
      scnt_ff      <= scnt_in;
      obyte_ff     <= obyte_in;
      oesc_ff      <= oesc_in;
      orej_ff      <= orej_in;
      olast_ff     <= olast_in;
   end

endmodule

// ----- hw/rtl/exp_golomb_nal_payload_writer.sv -----
// ----------------------------------------------------------------------------
// exp_golomb_nal_payload_writer
// Exp-Golomb metadata NAL payload writer with emulation prevention.
// ----------------------------------------------------------------------------
//   channel | direction | word contents
//   --------+-----------+-----------------------------------------------------
//   req_    | in        | tuser: operation; tdata: unsigned, signed, float bits
//   rsp_    | out       | tdata: byte; tuser: escape, rejected; tlast: last
//   csr_    | in        | data: header type byte (always ready)
//
// The front takes a new request word only when idle, after its entries are
// queued: the normaliser moves a byte or a fine step per cycle, and nonzero
// float words use it three times. The back puts up to 8 bits a cycle into
// the packer and sends one response word a cycle while not stalled; it pops
// each queue entry in its idle state. Reset is synchronous and clears the
// packer; recent bytes go to 0xFF, the header type to 24. A stalled response
// halts only the back; the queue lets the front keep accepting until full.
// ----------------------------------------------------------------------------
module exp_golomb_nal_payload_writer
   import egw_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [30:0] unsigned_value, [62:31] signed_value, [94:63] float_bits
   input  logic [95:0] req_tdata,
   // [2:0] operation
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] out_byte
   output logic [7:0]  rsp_tdata,
   // [0] is_escape, [1] rejected
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   logic [7:0]    hdr_type_ff, hdr_type_in;
   logic          q_push;
   egw_entry_type q_push_entry;
   logic          q_pop;
   egw_entry_type q_pop_entry;
   logic          q_full;
   logic          q_empty;

   assign csr_ready = 1'b1;

   always_comb begin
      hdr_type_in = hdr_type_ff;
      if (csr_valid) begin
         hdr_type_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_type_ff <= HDR_TYPE_RESET;
      end else begin
         hdr_type_ff <= hdr_type_in;
      end
   end

   egw_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_tvalid         (req_tvalid),
      .req_tready         (req_tready),
      .req_operation      (req_tuser),
      .req_unsigned_value (req_tdata[30:0]),
      .req_signed_value   (req_tdata[62:31]),
      .req_float_bits     (req_tdata[94:63]),
      .q_full             (q_full),
      .q_push             (q_push),
      .q_entry            (q_push_entry)
   );

   egw_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .pop        (q_pop),
      .pop_entry  (q_pop_entry),
      .full       (q_full),
      .empty      (q_empty)
   );

   egw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .hdr_type   (hdr_type_ff),
      .q_empty    (q_empty),
      .q_entry    (q_pop_entry),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- hw/rtl/egw_checker.sv -----
// ----------------------------------------------------------------------------
// egw_checker
// Port-level checks of the payload writer, bound to its top level.
// ----------------------------------------------------------------------------
module egw_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // no response word straight after reset
   a_reset_quiet : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // a stalled response word holds
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
         $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled response word changed");

   // a rejection is a single zero word that closes its item
   a_reject_form : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata == 8'h00 && !rsp_tuser[0] && rsp_tlast)
      else $error("malformed rejection");

   // an escape is 0x03, is not rejected and never closes its item, since its payload byte follows
   a_escape_form : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == 8'h03 && !rsp_tlast && !rsp_tuser[1])
      else $error("malformed escape byte");

endmodule

bind exp_golomb_nal_payload_writer egw_checker u_egw_checker (.*);
